// ----- design/skh_pkg.sv -----
// ----------------------------------------------------------------------------
// skh_pkg
// Shared types and constants of the keyed string hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package skh_pkg;

    // Longest string that is hashed; later characters are dropped
    localparam int MAX_LEN = 32;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // Cipher rounds per block
    localparam int ROUNDS = 34;
    localparam int RND_W  = $clog2(ROUNDS);

    localparam logic [7:0] CHAR_MASK = 8'h06;
    localparam logic [7:0] PAD_MARK  = 8'h80;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_INIT_K   = 2'd2;
    localparam logic [1:0] REG_INIT_J   = 2'd3;

    // Full 256-bit cipher key
    typedef struct packed {
        logic [63:0] k3;
        logic [63:0] k2;
        logic [63:0] k1;
        logic [63:0] k0;
    } key_t;

    // Command from the byte packer to the hash engine
    typedef struct packed {
        logic [127:0] block;
        logic         absorb;  // encipher block and fold into the hash
        logic         finish;  // pad, run the final pass and emit
        logic [3:0]   rem;     // character count modulo 16
    } blk_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ABSORB,
        BK_FINAL,
        BK_HOLD
    } back_state_t;

endpackage

`default_nettype wire

// ----- design/skh_front.sv -----
// ----------------------------------------------------------------------------
// skh_front
// Packs incoming characters into 16-byte blocks and issues block commands.
// ----------------------------------------------------------------------------
`default_nettype none

module skh_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_byte_value,
    input  wire logic              s_byte_valid,
    input  wire logic              s_last,
    output logic                   cmd_push,
    output skh_pkg::blk_cmd_t      cmd_data,
    input  wire logic              cmd_full
);

    logic [127:0]             buffer_reg, buffer_next;
    logic [skh_pkg::CNT_W-1:0] count_reg, count_next;

    logic [127:0]              buf_with;
    logic [skh_pkg::CNT_W-1:0] count_new;
    logic                      take;
    logic                      full_now;
    logic                      need_push;
    logic                      accept;
    logic [7:0]                masked;

    always_comb begin
        take      = s_byte_valid && (count_reg < skh_pkg::CNT_W'(skh_pkg::MAX_LEN));
        masked    = s_byte_value ^ skh_pkg::CHAR_MASK;
        buf_with  = buffer_reg;
        if (take) begin
            buf_with = buffer_reg | ({120'b0, masked} << {count_reg[3:0], 3'b000});
        end
        count_new = count_reg + skh_pkg::CNT_W'(take);
        full_now  = take && (count_new[3:0] == 4'd0);
        need_push = full_now || s_last;
        s_ready   = !(need_push && cmd_full);
        accept    = s_valid && s_ready;
        cmd_push  = accept && need_push;

        cmd_data.block  = buf_with;
        cmd_data.absorb = full_now || (count_new[3:0] != 4'd0);
        cmd_data.finish = s_last;
        cmd_data.rem    = count_new[3:0];

        buffer_next = buffer_reg;
        count_next  = count_reg;
        if (accept) begin
            if (s_last) begin
                buffer_next = '0;
                count_next  = '0;
            end else if (full_now) begin
                buffer_next = '0;
                count_next  = count_new;
            end else begin
                buffer_next = buf_with;
                count_next  = count_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_reg <= '0;
            count_reg  <= '0;
        end else begin
            buffer_reg <= buffer_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/skh_queue.sv -----
// ----------------------------------------------------------------------------
// skh_queue
// Two-entry command queue between the byte packer and the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

module skh_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire skh_pkg::blk_cmd_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   q_valid,
    output skh_pkg::blk_cmd_t      pop_data
);

    skh_pkg::blk_cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    always_comb begin
        full        = (fill_reg == 2'd2);
        q_valid     = (fill_reg != 2'd0);
        pop_data    = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/skh_cipher.sv -----
// ----------------------------------------------------------------------------
// skh_cipher
// Speck-128/256 block encryption, one round per cycle with on-the-fly key
// schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module skh_cipher (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [127:0]   block_in,
    input  wire skh_pkg::key_t  key_in,
    output logic                done,
    output logic [127:0]        ct_out
);

    logic [63:0] x0_reg, x1_reg, k0_reg, k1_reg, k2_reg, k3_reg;
    logic [63:0] x0_next, x1_next, k0_next, k1_next, k2_next, k3_next;
    logic [skh_pkg::RND_W-1:0] round_reg, round_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    logic [63:0] x0_rnd, x1_rnd, k1_rnd, k0_rnd;

    always_comb begin
        x0_rnd = ({x0_reg[7:0], x0_reg[63:8]} + x1_reg) ^ k0_reg;
        x1_rnd = {x1_reg[60:0], x1_reg[63:61]} ^ x0_rnd;
        k1_rnd = ({k1_reg[7:0], k1_reg[63:8]} + k0_reg)
                 ^ {{(64 - skh_pkg::RND_W){1'b0}}, round_reg};
        k0_rnd = {k0_reg[60:0], k0_reg[63:61]} ^ k1_rnd;

        x0_next    = x0_reg;
        x1_next    = x1_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        k2_next    = k2_reg;
        k3_next    = k3_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start) begin
            x0_next    = block_in[63:0];
            x1_next    = block_in[127:64];
            k0_next    = key_in.k0;
            k1_next    = key_in.k1;
            k2_next    = key_in.k2;
            k3_next    = key_in.k3;
            round_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            x0_next    = x0_rnd;
            x1_next    = x1_rnd;
            k0_next    = k0_rnd;
            // rotate the remaining key words
            k1_next    = k2_reg;
            k2_next    = k3_reg;
            k3_next    = k1_rnd;
            round_next = round_reg + skh_pkg::RND_W'(1);
            if (round_reg == skh_pkg::RND_W'(skh_pkg::ROUNDS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        done   = done_reg;
        ct_out = {x1_reg, x0_reg};
    end

    always_ff @(posedge aclk) begin
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        k3_reg    <= k3_next;
        round_reg <= round_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/skh_back.sv -----
// ----------------------------------------------------------------------------
// skh_back
// Hash engine: absorbs block ciphertexts, pads, runs the final pass and
// drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skh_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire skh_pkg::blk_cmd_t q_data,
    output logic                   q_pop,
    input  wire skh_pkg::key_t     key,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [63:0]            m_hash_low,
    output logic [63:0]            m_hash_high
);

    skh_pkg::back_state_t state_reg, state_next;

    logic [127:0] hash_reg, hash_next;
    logic [127:0] hsave_reg, hsave_next;
    logic         finish_reg, finish_next;
    logic [3:0]   rem_reg, rem_next;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] out_reg, out_next;

    logic         c_start;
    logic [127:0] c_block;
    logic         c_done;
    logic [127:0] c_ct;

    logic [127:0] hsum;
    logic         out_free;

    skh_cipher u_cipher (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (c_start),
        .block_in (c_block),
        .key_in   (key),
        .done     (c_done),
        .ct_out   (c_ct)
    );

    // Length padding into byte 0 and the end mark into word (rem & 3)
    function automatic logic [127:0] pad_hash(input logic [127:0] h, input logic [3:0] rem);
        logic [127:0] p;
        p = h;
        if (rem != 4'd0) begin
            p[7:0] = p[7:0] ^ {4'hF, rem};
        end
        p = p ^ ({120'b0, skh_pkg::PAD_MARK} << {rem[1:0], 5'b00000});
        return p;
    endfunction

    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        hsave_next     = hsave_reg;
        finish_next    = finish_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        c_start        = 1'b0;
        c_block        = q_data.block;
        hsum           = hash_reg ^ c_ct;
        out_free       = !out_valid_reg || m_ready;

        case (state_reg)
            skh_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    finish_next = q_data.finish;
                    rem_next    = q_data.rem;
                    c_start     = 1'b1;
                    if (q_data.absorb) begin
                        c_block    = q_data.block;
                        state_next = skh_pkg::BK_ABSORB;
                    end else begin
                        c_block    = pad_hash(hash_reg, q_data.rem);
                        hsave_next = c_block;
                        state_next = skh_pkg::BK_FINAL;
                    end
                end
            end
            skh_pkg::BK_ABSORB: begin
                if (c_done) begin
                    hash_next = hsum;
                    if (finish_reg) begin
                        c_start    = 1'b1;
                        c_block    = pad_hash(hsum, rem_reg);
                        hsave_next = c_block;
                        state_next = skh_pkg::BK_FINAL;
                    end else begin
                        state_next = skh_pkg::BK_IDLE;
                    end
                end
            end
            skh_pkg::BK_FINAL: begin
                if (c_done) begin
                    hash_next = '0;
                    if (out_free) begin
                        out_next       = hsave_reg ^ c_ct;
                        out_valid_next = 1'b1;
                        state_next     = skh_pkg::BK_IDLE;
                    end else begin
                        // hold the result until the output register frees
                        hsave_next = hsave_reg ^ c_ct;
                        state_next = skh_pkg::BK_HOLD;
                    end
                end
            end
            skh_pkg::BK_HOLD: begin
                if (out_free) begin
                    out_next       = hsave_reg;
                    out_valid_next = 1'b1;
                    state_next     = skh_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = skh_pkg::BK_IDLE;
            end
        endcase

        m_valid     = out_valid_reg;
        m_hash_low  = out_reg[63:0];
        m_hash_high = out_reg[127:64];
    end

    always_ff @(posedge aclk) begin
        hsave_reg  <= hsave_next;
        finish_reg <= finish_next;
        rem_reg    <= rem_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= skh_pkg::BK_IDLE;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/speck_keyed_string_hash_core.sv -----
// ----------------------------------------------------------------------------
// speck_keyed_string_hash_core
// Keyed 128-bit string hash over Speck-128/256, one character per transaction.
//
//   channel  dir  handshake         payload
//   s_       in   s_valid/s_ready   s_byte_value[7:0], s_byte_valid, s_last
//   m_       out  m_valid/m_ready   m_hash_low[63:0], m_hash_high[63:0]
//   cfg_     in   cfg_we            cfg_index[1:0], cfg_data[63:0]
//
// Each 16-byte block holds the engine while it is issued, run through the
// 34 cipher rounds and collected. The end of a string adds a final pass
// through the cipher, so a final partial block shows its hash only after
// its own block pass and then the final pass. A two-entry command queue lets
// characters keep arriving while the cipher works; input stalls only when
// the queue is full. Reset is synchronous and clears the key registers,
// packer and hash state.
// ----------------------------------------------------------------------------
`default_nettype none

module speck_keyed_string_hash_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_value,
    input  wire logic        s_byte_valid,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_hash_low,
    output logic [63:0]      m_hash_high,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] key_low_reg, key_high_reg, init_k_reg, init_j_reg;

    skh_pkg::key_t     key;
    skh_pkg::blk_cmd_t push_cmd, pop_cmd;
    logic              cmd_push, cmd_full, cmd_valid, cmd_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            init_k_reg   <= '0;
            init_j_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                skh_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                skh_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                skh_pkg::REG_INIT_K:   init_k_reg   <= cfg_data;
                skh_pkg::REG_INIT_J:   init_j_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        key.k0 = key_low_reg;
        key.k1 = key_high_reg;
        key.k2 = key_low_reg ^ init_k_reg;
        key.k3 = key_high_reg ^ init_j_reg;
    end

    skh_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .s_byte_valid (s_byte_valid),
        .s_last       (s_last),
        .cmd_push     (cmd_push),
        .cmd_data     (push_cmd),
        .cmd_full     (cmd_full)
    );

    skh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .q_valid   (cmd_valid),
        .pop_data  (pop_cmd)
    );

    skh_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (cmd_valid),
        .q_data      (pop_cmd),
        .q_pop       (cmd_pop),
        .key         (key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hash_low  (m_hash_low),
        .m_hash_high (m_hash_high)
    );

endmodule

`default_nettype wire

// ----- tb/sv/speck_keyed_string_hash_core_test.sv -----
// ----------------------------------------------------------------------------
// speck_keyed_string_hash_core_test
// Self-checking bench for the keyed Speck string hash core. Strings are fed
// one character per transaction, and each emitted hash is compared against
// an in-bench Speck-128/256 hash predictor. The run covers several key
// settings, random sender and receiver idling, and a long receiver hold-off
// that backs the core up.
// ----------------------------------------------------------------------------
module speck_keyed_string_hash_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 200;
    localparam int TIMEOUT_NS    = 4_000_000;
    localparam int HOLD_OFF_LEN  = 600;

    typedef struct {
        logic [7:0] value;
        logic       valid;
        logic       last;
    } char_item_t;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } hash_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = '0;
    logic        s_byte_valid = 1'b0;
    logic        s_last       = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [63:0] m_hash_low;
    logic [63:0] m_hash_high;
    logic        cfg_we       = 1'b0;
    logic [1:0]  cfg_index    = '0;
    logic [63:0] cfg_data     = '0;

    // Stimulus and expectation stores
    char_item_t pending_chars[$];
    hash_t      expected_hashes[$];
    char_item_t next_char;
    logic       in_taken = 1'b0;

    // Idling controls, written by the stimulus process at a rising edge
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;

    // Predictor state
    logic [63:0]  key_lo = '0;
    logic [63:0]  key_hi = '0;
    logic [63:0]  key_init_k = '0;
    logic [63:0]  key_init_j = '0;
    logic [127:0] blk_buf = '0;
    logic [127:0] hash_acc = '0;
    int           char_count = 0;

    int errors = 0;
    int hashes_checked = 0;
    int chars_taken = 0;
    int key_settings = 1;

    speck_keyed_string_hash_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .s_byte_valid (s_byte_valid),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_low   (m_hash_low),
        .m_hash_high  (m_hash_high),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Speck-128/256 encryption of {x1, x0} under the current key registers
    function automatic logic [127:0] speck_encrypt(logic [127:0] pt);
        logic [63:0] x0, x1, k0, k1, k2, k3, t;
        x0 = pt[63:0];
        x1 = pt[127:64];
        k0 = key_lo;
        k1 = key_hi;
        k2 = key_lo ^ key_init_k;
        k3 = key_hi ^ key_init_j;
        for (int i = 0; i < skh_pkg::ROUNDS; i++) begin
            x0 = ({x0[7:0], x0[63:8]} + x1) ^ k0;
            x1 = {x1[60:0], x1[63:61]} ^ x0;
            k1 = ({k1[7:0], k1[63:8]} + k0) ^ 64'(i);
            k0 = {k0[60:0], k0[63:61]} ^ k1;
            t  = k1;
            k1 = k2;
            k2 = k3;
            k3 = t;
        end
        return {x1, x0};
    endfunction

    function automatic void absorb_block();
        hash_acc = hash_acc ^ speck_encrypt(blk_buf);
        blk_buf  = '0;
    endfunction

    // Advance the predictor by one accepted transaction
    function automatic void fold_char(logic [7:0] ch, logic vld, logic lst);
        int           r;
        logic [127:0] h;
        hash_t        e;
        if (vld && char_count < skh_pkg::MAX_LEN) begin
            blk_buf[(char_count % 16) * 8 +: 8] = ch ^ skh_pkg::CHAR_MASK;
            char_count++;
            chars_taken++;
            if (char_count % 16 == 0)
                absorb_block();
        end
        if (lst) begin
            r = char_count % 16;
            if (r != 0)
                absorb_block();
            h = hash_acc;
            h[7:0] = h[7:0] ^ ((r == 0) ? 8'h00 : 8'(r + 240));
            h[(r % 4) * 32 +: 8] = h[(r % 4) * 32 +: 8] ^ skh_pkg::PAD_MARK;
            h = h ^ speck_encrypt(h);
            e.lo = h[63:0];
            e.hi = h[127:64];
            expected_hashes.push_back(e);
            blk_buf    = '0;
            hash_acc   = '0;
            char_count = 0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_hash();
        hash_t e;
        if (expected_hashes.size() == 0) begin
            report_mismatch($sformatf("unexpected hash %h_%h", m_hash_high, m_hash_low));
        end else begin
            e = expected_hashes.pop_front();
            hashes_checked++;
            if (m_hash_low !== e.lo)
                report_mismatch($sformatf("hash_low got %h want %h", m_hash_low, e.lo));
            if (m_hash_high !== e.hi)
                report_mismatch($sformatf("hash_high got %h want %h", m_hash_high, e.hi));
        end
    endtask

    // Sample both channels on the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                fold_char(s_byte_value, s_byte_valid, s_last);
            if (m_valid && m_ready)
                check_hash();
        end
    end

    // Sender: hold the payload until taken, then advance or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_char = pending_chars.pop_front();
                s_valid      <= 1'b1;
                s_byte_value <= next_char.value;
                s_byte_valid <= next_char.valid;
                s_last       <= next_char.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: long hold-off when requested, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_len > 0) begin
            m_ready  <= 1'b0;
            hold_len <= hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            skh_pkg::REG_KEY_LOW:  key_lo     = val;
            skh_pkg::REG_KEY_HIGH: key_hi     = val;
            skh_pkg::REG_INIT_K:   key_init_k = val;
            skh_pkg::REG_INIT_J:   key_init_j = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_key(logic [63:0] lo, logic [63:0] hi, logic [63:0] k, logic [63:0] j);
        write_reg(skh_pkg::REG_KEY_LOW, lo);
        write_reg(skh_pkg::REG_KEY_HIGH, hi);
        write_reg(skh_pkg::REG_INIT_K, k);
        write_reg(skh_pkg::REG_INIT_J, j);
        key_settings++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_char(logic [7:0] v, logic vld, logic lst);
        char_item_t c;
        c.value = v;
        c.valid = vld;
        c.last  = lst;
        pending_chars.push_back(c);
    endfunction

    // Wait until every queued transaction is taken and every hash has come
    task automatic wait_results();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_chars.size() != 0 || s_valid || expected_hashes.size() != 0);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int pick_len();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(17, 15);
            2:       return $urandom_range(33, 31);
            3:       return $urandom_range(45, 34);
            default: return $urandom_range(14, 1);
        endcase
    endfunction

    // Queue one string with random content; end it on a character or a bare marker
    function automatic int queue_string(int len);
        logic on_char;
        on_char = (len > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                push_char(8'($urandom), 1'b0, 1'b0);
            push_char(8'($urandom), 1'b1, on_char && (i == len - 1));
        end
        if (!on_char)
            push_char(8'($urandom), 1'b0, 1'b1);
        return len;
    endfunction

    task automatic queue_random_strings(int n_chars, int pause_every);
        int added;
        int strings;
        added = 0;
        strings = 0;
        while (added < n_chars) begin
            if ($urandom_range(19) == 0)
                push_char(8'($urandom), 1'b0, 1'b0);
            added += queue_string(pick_len());
            strings++;
            if (pause_every > 0 && strings % pause_every == 0)
                wait_results();
        end
    endtask

    initial begin
        #TIMEOUT_NS;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset key, no idling: directed strings first
        push_char(8'hFF, 1'b0, 1'b1);               // empty string
        push_char(8'h00, 1'b1, 1'b1);               // lone zero character
        push_char(8'hFF, 1'b1, 1'b0);
        push_char(8'hA5, 1'b0, 1'b0);               // idle between characters
        push_char(8'h80, 1'b1, 1'b1);
        push_char(8'h01, 1'b1, 1'b0);
        push_char(8'h7F, 1'b1, 1'b0);
        push_char(8'h5A, 1'b0, 1'b1);               // ended by a bare marker
        for (int i = 0; i < 16; i++)
            push_char(8'hF0 + 8'(i), 1'b1, i == 15); // exactly one full block
        queue_random_strings(120, 0);
        wait_idle();

        // All-ones key, sender idling
        load_key('1, '1, '1, '1);
        send_idle_pct = 61;
        queue_random_strings(180, 0);
        wait_idle();

        // Random key, receiver stalling, with a long hold-off up front
        load_key(rand64(), rand64(), rand64(), rand64());
        send_idle_pct  = 0;
        recv_stall_pct = 61;
        hold_len = HOLD_OFF_LEN;
        queue_random_strings(120, 0);
        wait_results();
        queue_random_strings(120, 0);
        wait_idle();

        // Random key, both sides idling
        load_key(rand64(), rand64(), rand64(), rand64());
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        queue_random_strings(180, 0);
        wait_idle();

        // Mixed extremes, no idling, sender pausing for results now and then
        load_key('0, '1, '1, '0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_strings(180, 4);
        wait_idle();

        $display("Checked %0d hashes over %0d accepted characters under %0d key settings,",
                 hashes_checked, chars_taken, key_settings);
        $display("with free-running, idling, stalling and held-off handshakes.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
